/* hdl/sfr_pkg.sv */
// Package for the stream find-and-replace unit: payload structs, cell control,
// sequencer states and configuration register indexes.
// No dependencies.
package sfr_pkg;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_valid;
      logic       out_last;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic shift;
   } cell_ctrl_type;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SCAN  = 4'b0010,
      ST_REPL  = 4'b0100,
      ST_FLUSH = 4'b1000
   } state_type;

   localparam logic [1:0] CSR_PATTERN_BYTES      = 2'd0;
   localparam logic [1:0] CSR_PATTERN_LENGTH     = 2'd1;
   localparam logic [1:0] CSR_REPLACEMENT_BYTES  = 2'd2;
   localparam logic [1:0] CSR_REPLACEMENT_LENGTH = 2'd3;

endpackage

/* hdl/sfr_cell.sv */
// One cell of the pending byte chain: holds one byte and compares it with
// its pattern byte. Depends on sfr_pkg.
module sfr_cell (
   input  logic                  clock,
   input  sfr_pkg::cell_ctrl_type ctrl,
   input  logic [7:0]            load_byte,
   input  logic [7:0]            next_byte,
   input  logic [7:0]            pattern_byte,
   output logic [7:0]            data,
   output logic                  hit
);

   logic [7:0] data_ff;
   logic [7:0] data_in;

   always_comb begin
      priority if (ctrl.load) begin
         data_in = load_byte;
      end else if (ctrl.shift) begin
         data_in = next_byte;
      end else begin
         data_in = data_ff;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;
   assign hit  = (data_ff == pattern_byte);

endmodule

/* hdl/stream_find_replace_unit.sv */
// Stream find-and-replace: one byte per transfer in, rewritten bytes out.
// An input byte is loaded into the pending chain in ST_IDLE; ST_SCAN then
// registers popped bytes into the result register, ST_REPL the replacement
// bytes and ST_FLUSH the remaining bytes or a bare end marker. No new byte is
// taken until the sequencer is back in ST_IDLE; rsp_stall holds it back, and
// the single-byte result register paces it. Reset (synchronous) empties the
// pending chain and restores the register defaults.
module stream_find_replace_unit #(
   parameter int MAX_PATTERN     = 8,
   parameter int MAX_REPLACEMENT = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  sfr_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output sfr_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [63:0]      csr_wdata
);

   localparam int CNT_W  = $clog2(MAX_PATTERN + 1);
   localparam int RCNT_W = (MAX_REPLACEMENT > 0) ? $clog2(MAX_REPLACEMENT + 1) : 1;

   logic [63:0] pattern_bytes_ff;
   logic [3:0]  pattern_length_ff;
   logic [63:0] replacement_bytes_ff;
   logic [3:0]  replacement_length_ff;

   sfr_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [RCNT_W-1:0]  ridx_ff, ridx_in;
   logic               shifted_ff, shifted_in;
   logic               last_ff, last_in;
   logic               emitted_ff, emitted_in;
   logic               rsp_valid_ff, rsp_valid_in;
   sfr_pkg::rsp_type   rsp_data_ff, rsp_data_in;

   logic [3:0]        plen_eff;
   logic [3:0]        rlen_eff;
   logic              prefix_ok;
   logic              out_free;
   logic              emit;
   sfr_pkg::rsp_type  emit_data;
   logic              load;
   logic              pop;
   logic [7:0]        rep_byte;

   logic [7:0]             cell_byte [MAX_PATTERN];
   logic [MAX_PATTERN-1:0] cell_hit;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_bytes_ff      <= '0;
         pattern_length_ff     <= 4'd1;
         replacement_bytes_ff  <= '0;
         replacement_length_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            sfr_pkg::CSR_PATTERN_BYTES:      pattern_bytes_ff      <= csr_wdata;
            sfr_pkg::CSR_PATTERN_LENGTH:     pattern_length_ff     <= csr_wdata[3:0];
            sfr_pkg::CSR_REPLACEMENT_BYTES:  replacement_bytes_ff  <= csr_wdata;
            sfr_pkg::CSR_REPLACEMENT_LENGTH: replacement_length_ff <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      priority if (pattern_length_ff == 4'd0) begin
         plen_eff = 4'd1;
      end else if (pattern_length_ff > 4'(MAX_PATTERN)) begin
         plen_eff = 4'(MAX_PATTERN);
      end else begin
         plen_eff = pattern_length_ff;
      end
      if (replacement_length_ff > 4'(MAX_REPLACEMENT)) begin
         rlen_eff = 4'(MAX_REPLACEMENT);
      end else begin
         rlen_eff = replacement_length_ff;
      end
   end

   // pending byte chain
   for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
      sfr_pkg::cell_ctrl_type ctrl;
      logic [7:0]             next_byte;

      assign ctrl.load  = load && (count_ff == CNT_W'(i));
      assign ctrl.shift = pop;

      if (i == MAX_PATTERN - 1) begin : g_end
         assign next_byte = 8'h00;
      end else begin : g_mid
         assign next_byte = cell_byte[i+1];
      end

      sfr_cell u_cell (
         .clock        (clock),
         .ctrl         (ctrl),
         .load_byte    (req_data.in_byte),
         .next_byte    (next_byte),
         .pattern_byte (pattern_bytes_ff[8*i +: 8]),
         .data         (cell_byte[i]),
         .hit          (cell_hit[i])
      );
   end

   always_comb begin
      prefix_ok = 1'b1;
      for (int i = 0; i < MAX_PATTERN; i++) begin
         if (CNT_W'(i) < count_ff && !cell_hit[i]) begin
            prefix_ok = 1'b0;
         end
      end
   end

   assign rep_byte = 8'(replacement_bytes_ff >> {ridx_ff, 3'b000});
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // sequencer
   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      ridx_in    = ridx_ff;
      shifted_in = shifted_ff;
      last_in    = last_ff;
      emit       = 1'b0;
      emit_data  = '0;
      load       = 1'b0;
      pop        = 1'b0;

      unique case (state_ff)
         sfr_pkg::ST_IDLE: begin
            if (req_valid) begin
               load       = 1'b1;
               count_in   = count_ff + CNT_W'(1);
               last_in    = req_data.in_last;
               shifted_in = 1'b0;
               state_in   = sfr_pkg::ST_SCAN;
            end
         end
         sfr_pkg::ST_SCAN: begin
            priority if (!shifted_ff && 4'(count_ff) == plen_eff && prefix_ok) begin
               count_in = '0;
               ridx_in  = '0;
               state_in = sfr_pkg::ST_REPL;
            end else if (4'(count_ff) < plen_eff && prefix_ok) begin
               state_in = last_ff ? sfr_pkg::ST_FLUSH : sfr_pkg::ST_IDLE;
            end else if (out_free) begin
               emit                = 1'b1;
               emit_data.out_byte  = cell_byte[0];
               emit_data.out_valid = 1'b1;
               emit_data.out_last  = last_ff && (count_ff == CNT_W'(1));
               pop                 = 1'b1;
               count_in            = count_ff - CNT_W'(1);
               shifted_in          = 1'b1;
            end
         end
         sfr_pkg::ST_REPL: begin
            priority if (4'(ridx_ff) == rlen_eff) begin
               state_in = last_ff ? sfr_pkg::ST_FLUSH : sfr_pkg::ST_IDLE;
            end else if (out_free) begin
               emit                = 1'b1;
               emit_data.out_byte  = rep_byte;
               emit_data.out_valid = 1'b1;
               emit_data.out_last  = last_ff && (4'(ridx_ff) + 4'd1 == rlen_eff);
               ridx_in             = ridx_ff + RCNT_W'(1);
            end
         end
         sfr_pkg::ST_FLUSH: begin
            priority if (count_ff == '0) begin
               if (emitted_ff) begin
                  state_in = sfr_pkg::ST_IDLE;
               end else if (out_free) begin
                  // bare end marker
                  emit               = 1'b1;
                  emit_data.out_last = 1'b1;
                  state_in           = sfr_pkg::ST_IDLE;
               end
            end else if (out_free) begin
               emit                = 1'b1;
               emit_data.out_byte  = cell_byte[0];
               emit_data.out_valid = 1'b1;
               emit_data.out_last  = (count_ff == CNT_W'(1));
               pop                 = 1'b1;
               count_in            = count_ff - CNT_W'(1);
            end
         end
         default: begin
            state_in = sfr_pkg::ST_IDLE;
         end
      endcase

      emitted_in = load ? 1'b0 : (emitted_ff || emit);
   end

   always_comb begin
      rsp_valid_in = emit || (rsp_valid_ff && rsp_stall);
      rsp_data_in  = emit ? emit_data : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sfr_pkg::ST_IDLE;
         count_ff     <= '0;
         ridx_ff      <= '0;
         shifted_ff   <= 1'b0;
         last_ff      <= 1'b0;
         emitted_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ridx_ff      <= ridx_in;
         shifted_ff   <= shifted_in;
         last_ff      <= last_in;
         emitted_ff   <= emitted_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = (state_ff != sfr_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef ASSERT_OFF
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_PATTERN))
      else $error("pending count out of range");

   a_bare_marker_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.out_valid) |-> rsp_data.out_last)
      else $error("empty transfer without end mark");

   a_repl_empty_chain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sfr_pkg::ST_REPL) |-> (count_ff == '0))
      else $error("pending bytes left during replacement");

   a_pop_emits: assert property (@(posedge clock) disable iff (reset)
      pop |=> (rsp_valid && rsp_data.out_valid))
      else $error("popped byte not presented");
`endif

endmodule
